// ===== sv/assert_macros.svh =====
// Assertion macros shared by the sorted list RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge out of reset.
`define SLIR_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Condition in one cycle that implies another in the next cycle.
`define SLIR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/slir_pkg.sv =====
// Types and constants shared by the sorted list modules.
package slir_pkg;

    // key width
    localparam int unsigned VAL_W = 32;
    // result count field width
    localparam int unsigned CNT_FIELD_W = 5;

    // operation codes carried in tuser
    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_REMOVE = 1'b1;

    // result status codes
    typedef enum logic [1:0] {
        ST_INSERTED  = 2'd0,
        ST_REMOVED   = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    // update command broadcast to every cell
    typedef struct packed {
        logic ins;   // insert key at the first cell not below it
        logic rem;   // remove the first cell equal to key
    } cell_cmd_t;

    // compare flags a cell reports
    typedef struct packed {
        logic lt;    // occupied and holds a value below key
        logic eq;    // occupied and holds key
    } cell_flags_t;

    // registered result word
    typedef struct packed {
        logic signed [VAL_W-1:0] smallest;
        logic                    is_empty;
        logic [CNT_FIELD_W-1:0]  entry_count;
        status_t                 status;
    } result_t;

endpackage

// ===== sv/slir_cell.sv =====
// One storage cell of the sorted chain: compare against the key and shift.
module slir_cell
(
    input  logic                              clk,
    input  logic                              occ,        // cell holds a live entry
    input  slir_pkg::cell_cmd_t               cmd,
    input  logic signed [slir_pkg::VAL_W-1:0] key,
    input  logic                              left_lt,    // left neighbor stays put
    input  logic signed [slir_pkg::VAL_W-1:0] left_val,
    input  logic signed [slir_pkg::VAL_W-1:0] right_val,
    output slir_pkg::cell_flags_t             flags,
    output logic signed [slir_pkg::VAL_W-1:0] val,
    output logic signed [slir_pkg::VAL_W-1:0] val_next
);
    import slir_pkg::*;

    logic signed [VAL_W-1:0] val_reg;

    // compare against the broadcast key
    assign flags.lt = occ && (val_reg < key);
    assign flags.eq = occ && (val_reg == key);

    // cells at or past the split point move: right on insert, left on remove
    always_comb
    begin
        val_next = val_reg;
        if (cmd.ins && !flags.lt)
        begin
            val_next = left_lt ? key : left_val;
        end
        else if (cmd.rem && !flags.lt)
        begin
            val_next = right_val;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    assign val = val_reg;

endmodule

// ===== sv/sorted_list_insert_remove.sv =====
// Top level of the sorted list store: cell chain, entry count and result register.
//
//  channel  | dir | tdata (low bit up)                                  | tuser
//  ---------+-----+-----------------------------------------------------+-----------
//  s_*      | in  | value[31:0]                                         | mode[0]
//  m_*      | out | status[1:0] entry_count[6:2] is_empty[7] smallest   | -
//           |     | [39:8], zero fill none (40 bits)                    |
//
// One word per cycle while s_tready is high: every cell compares against the
// key in parallel and the cells at or past the split point shift one place
// toward a neighbor. The result word is registered; m_tvalid rises in the cycle after accept.
// s_tready is low only while a result waits and m_tready is low.
// rst_n clears the entry count and the result valid flag; cell contents and
// the result data are don't-care until written.
module sorted_list_insert_remove
#(
    parameter int unsigned CAPACITY = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // value[31:0]
    input  logic        s_tuser,   // mode[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // status[1:0] entry_count[6:2] is_empty[7] smallest[39:8]
);
    import slir_pkg::*;

    `include "assert_macros.svh"

    localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

    logic                    accept;
    logic                    full;
    logic                    found;
    logic signed [VAL_W-1:0] key;
    cell_cmd_t               cmd;
    status_t                 status;
    logic [CNT_W-1:0]        count_reg;
    logic [CNT_W-1:0]        count_next;
    logic [CNT_W+CNT_FIELD_W-1:0] count_ext;
    logic                    out_valid_reg;
    result_t                 out_data_reg;
    result_t                 out_data_next;
    logic                    empty_ok;

    logic signed [VAL_W-1:0] vals      [CAPACITY];
    logic signed [VAL_W-1:0] vals_next [CAPACITY];
    cell_flags_t             flags     [CAPACITY];
    logic [CAPACITY-1:0]     eqs;

    assign key      = $signed(s_tdata);
    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign full     = (count_reg == CNT_W'(CAPACITY));
    assign found    = |eqs;

    // command broadcast to the chain
    assign cmd.ins = accept && (s_tuser == MODE_INSERT) && !full;
    assign cmd.rem = accept && (s_tuser == MODE_REMOVE) && found;

    // cell chain
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic                    occ;
        logic                    left_lt;
        logic signed [VAL_W-1:0] left_val;
        logic signed [VAL_W-1:0] right_val;

        assign occ = (count_reg > CNT_W'(i));
        assign eqs[i] = flags[i].eq;

        if (i == 0)
        begin : g_head
            assign left_lt  = 1'b1;
            assign left_val = key;
        end
        else
        begin : g_mid
            assign left_lt  = flags[i-1].lt;
            assign left_val = vals[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_tail
            assign right_val = '0;
        end
        else
        begin : g_body
            assign right_val = vals[i+1];
        end

        slir_cell u_cell
        (
            .clk       (clk),
            .occ       (occ),
            .cmd       (cmd),
            .key       (key),
            .left_lt   (left_lt),
            .left_val  (left_val),
            .right_val (right_val),
            .flags     (flags[i]),
            .val       (vals[i]),
            .val_next  (vals_next[i])
        );
    end

    // entry count and status
    always_comb
    begin
        count_next = count_reg;
        priority if (cmd.ins)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (cmd.rem)
        begin
            count_next = count_reg - 1'b1;
        end
        else
        begin
            count_next = count_reg;
        end
    end

    always_comb
    begin
        priority if (s_tuser == MODE_INSERT)
        begin
            status = full ? ST_FULL : ST_INSERTED;
        end
        else
        begin
            status = found ? ST_REMOVED : ST_NOT_FOUND;
        end
    end

    // result word, built from the chain's next state
    assign count_ext = {{CNT_FIELD_W{1'b0}}, count_next};

    always_comb
    begin
        out_data_next.status      = status;
        out_data_next.entry_count = count_ext[CNT_FIELD_W-1:0];
        out_data_next.is_empty    = (count_next == '0);
        out_data_next.smallest    = (count_next == '0) ? '0 : vals_next[0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // empty flag matches the count field while it is wide enough
    assign empty_ok = (CAPACITY > 31) ||
                      (out_data_reg.is_empty == (out_data_reg.entry_count == '0));

    // checks
    `SLIR_ASSERT_ALWAYS(a_count_bound, count_reg <= CNT_W'(CAPACITY), "count above capacity")
    `SLIR_ASSERT_NEXT(a_ins_status, cmd.ins, out_data_reg.status == ST_INSERTED, "bad insert status")
    `SLIR_ASSERT_NEXT(a_ins_count, cmd.ins, count_reg == $past(count_reg) + 1'b1, "insert count")
    `SLIR_ASSERT_NEXT(a_no_change, !cmd.ins && !cmd.rem, count_reg == $past(count_reg), "count moved")
    `SLIR_ASSERT_ALWAYS(a_empty_flag, !out_valid_reg || empty_ok, "empty flag disagrees with count")

endmodule
